// ----- hdl/cbr_pkg.sv -----
`default_nettype none

package cbr_pkg;

  // default geometry
  localparam int KERNEL_SIZE_DEF  = 5;
  localparam int IMAGE_WIDTH_DEF  = 32;
  localparam int IMAGE_HEIGHT_DEF = 32;

  // field widths
  localparam int IDX_W     = 5;
  localparam int COEF_W    = 18;
  localparam int PIX_W     = 8;
  localparam int FEAT_W    = 31;
  localparam int POS_OUT_W = 5;
  // wide enough for any row or column counter plus a sign-free difference
  localparam int POS_W     = 9;
  // unsigned pixel (with a zero sign bit) times signed coefficient
  localparam int PROD_W    = PIX_W + 1 + COEF_W;

  localparam logic [FEAT_W-1:0] FEATURE_MAX = '1;

  typedef enum logic [1:0] {
    OP_PIXEL  = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_BIAS   = 2'd2
  } cbr_op_e;

  typedef struct packed {
    logic [POS_OUT_W-1:0] out_row;
    logic [POS_OUT_W-1:0] out_col;
    logic                 map_done;
  } cbr_tag_t;

  typedef struct packed {
    logic [FEAT_W-1:0]    feature;
    logic [POS_OUT_W-1:0] out_row;
    logic [POS_OUT_W-1:0] out_col;
    logic                 map_done;
  } cbr_result_t;

endpackage

`default_nettype wire

// ----- hdl/cbr_window.sv -----
`default_nettype none

module cbr_window import cbr_pkg::*; #(
  parameter int KERNEL_SIZE  = KERNEL_SIZE_DEF,
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire cbr_op_e                  in_op_i,
  input  wire logic [IDX_W-1:0]         in_idx_i,
  input  wire logic signed [COEF_W-1:0] in_coef_i,
  input  wire logic [PIX_W-1:0]         in_pixel_i,
  output logic                          prod_valid_o,
  input  wire logic                     prod_ready_i,
  output logic signed [PROD_W-1:0]      prod_o [KERNEL_SIZE*KERNEL_SIZE],
  output logic signed [COEF_W-1:0]      bias_o,
  output cbr_tag_t                      tag_o
);

  localparam int TAPS   = KERNEL_SIZE * KERNEL_SIZE;
  localparam int COL_W  = $clog2(IMAGE_WIDTH);
  localparam int ROWC_W = $clog2(IMAGE_HEIGHT);
  localparam int LB_W   = KERNEL_SIZE * PIX_W;

  // position of the next pixel
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROWC_W-1:0] row_q, row_d;

  // input stage
  logic                     a_valid_q;
  cbr_op_e                  a_op_q;
  logic [IDX_W-1:0]         a_idx_q;
  logic signed [COEF_W-1:0] a_coef_q;
  logic [PIX_W-1:0]         a_px_q;
  logic [COL_W-1:0]         a_col_q;
  logic [ROWC_W-1:0]        a_row_q;

  // line store, one word per column holding the older rows
  logic [LB_W-1:0]  lb_mem [IMAGE_WIDTH];
  logic [LB_W-1:0]  lb_rd_q;
  logic [LB_W-1:0]  lb_wr_word;

  logic [PIX_W-1:0] win_q [KERNEL_SIZE][KERNEL_SIZE];
  logic [PIX_W-1:0] win_d [KERNEL_SIZE][KERNEL_SIZE];
  logic [PIX_W-1:0] col_vec [KERNEL_SIZE];

  logic signed [COEF_W-1:0] weight_q [TAPS];
  logic signed [COEF_W-1:0] bias_q;

  // product stage
  logic                     b_valid_q;
  logic signed [PROD_W-1:0] prod_q [TAPS];
  logic signed [PROD_W-1:0] prod_d [TAPS];
  logic signed [COEF_W-1:0] b_bias_q;
  cbr_tag_t                 b_tag_q;
  cbr_tag_t                 tag_d;

  logic accept, a_ready, b_ready, a_fire, a_pix, emit;
  logic [POS_W-1:0] rdiff, cdiff;

  assign b_ready    = !b_valid_q || prod_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign accept     = in_valid_i && a_ready;
  assign a_fire     = a_valid_q && b_ready;
  assign a_pix      = (a_op_q == OP_PIXEL);
  assign in_ready_o = a_ready;

  assign emit = (a_row_q >= ROWC_W'(KERNEL_SIZE - 1)) && (a_col_q >= COL_W'(KERNEL_SIZE - 1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept && in_op_i == OP_PIXEL) begin
      if (col_q == COL_W'(IMAGE_WIDTH - 1)) begin
        col_d = '0;
        row_d = (row_q == ROWC_W'(IMAGE_HEIGHT - 1)) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q && a_pix && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_op_q   <= in_op_i;
      a_idx_q  <= in_idx_i;
      a_coef_q <= in_coef_i;
      a_px_q   <= in_pixel_i;
      a_col_q  <= col_q;
      a_row_q  <= row_q;
    end
  end

  // read at accept, write back when the pixel leaves the input stage;
  // back-to-back pixels always sit in different columns
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lb_rd_q <= lb_mem[col_q];
    end
    if (a_fire && a_pix) begin
      lb_mem[a_col_q] <= lb_wr_word;
    end
  end

  // new column: older rows from the line store, newest pixel at the bottom
  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      if (i < KERNEL_SIZE - 1) begin
        col_vec[i] = lb_rd_q[i*PIX_W +: PIX_W];
      end else begin
        col_vec[i] = a_px_q;
      end
    end
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      if (i < KERNEL_SIZE - 1) begin
        lb_wr_word[i*PIX_W +: PIX_W] = col_vec[i+1];
      end else begin
        lb_wr_word[i*PIX_W +: PIX_W] = a_px_q;
      end
    end
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        if (j < KERNEL_SIZE - 1) begin
          win_d[i][j] = win_q[i][j+1];
        end else begin
          win_d[i][j] = col_vec[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire && a_pix) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TAPS; t++) begin
        weight_q[t] <= '0;
      end
      bias_q <= '0;
    end else if (a_fire) begin
      case (a_op_q)
        OP_WEIGHT: begin
          for (int t = 0; t < TAPS; t++) begin
            if (int'(a_idx_q) == t) begin
              weight_q[t] <= a_coef_q;
            end
          end
        end
        OP_BIAS: begin
          bias_q <= a_coef_q;
        end
        default: begin
        end
      endcase
    end
  end

  // all taps multiply in parallel against the updated window
  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        prod_d[i*KERNEL_SIZE+j] = $signed({1'b0, win_d[i][j]}) * weight_q[i*KERNEL_SIZE+j];
      end
    end
  end

  assign rdiff = POS_W'(a_row_q) - POS_W'(KERNEL_SIZE - 1);
  assign cdiff = POS_W'(a_col_q) - POS_W'(KERNEL_SIZE - 1);

  always_comb begin
    tag_d.out_row  = rdiff[POS_OUT_W-1:0];
    tag_d.out_col  = cdiff[POS_OUT_W-1:0];
    tag_d.map_done = (a_row_q == ROWC_W'(IMAGE_HEIGHT - 1))
                  && (a_col_q == COL_W'(IMAGE_WIDTH - 1));
  end

  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      prod_q   <= prod_d;
      b_bias_q <= bias_q;
      b_tag_q  <= tag_d;
    end
  end

  assign prod_valid_o = b_valid_q;
  assign prod_o       = prod_q;
  assign bias_o       = b_bias_q;
  assign tag_o        = b_tag_q;

endmodule

`default_nettype wire

// ----- hdl/cbr_sum.sv -----
`default_nettype none

module cbr_sum import cbr_pkg::*; #(
  parameter int KERNEL_SIZE = KERNEL_SIZE_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     prod_valid_i,
  output logic                          prod_ready_o,
  input  wire logic signed [PROD_W-1:0] prod_i [KERNEL_SIZE*KERNEL_SIZE],
  input  wire logic signed [COEF_W-1:0] bias_i,
  input  wire cbr_tag_t                 tag_i,
  output logic                          res_valid_o,
  input  wire logic                     res_ready_i,
  output cbr_result_t                   res_o
);

  localparam int ROW_W   = PROD_W + $clog2(KERNEL_SIZE);
  localparam int ACC_RAW = ROW_W + $clog2(KERNEL_SIZE) + 1;
  localparam int ACC_W   = (ACC_RAW > FEAT_W + 1) ? ACC_RAW : FEAT_W + 1;

  // kernel-row sums
  logic                     c_valid_q;
  logic signed [ROW_W-1:0]  row_sum_q [KERNEL_SIZE];
  logic signed [ROW_W-1:0]  row_sum_d [KERNEL_SIZE];
  logic signed [COEF_W-1:0] c_bias_q;
  cbr_tag_t                 c_tag_q;

  // full sum with bias
  logic                     d_valid_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  cbr_tag_t                 d_tag_q;

  logic c_ready, d_ready;

  assign d_ready      = !d_valid_q || res_ready_i;
  assign c_ready      = !c_valid_q || d_ready;
  assign prod_ready_o = c_ready;

  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      row_sum_d[i] = '0;
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        row_sum_d[i] = row_sum_d[i] + ROW_W'(prod_i[i*KERNEL_SIZE+j]);
      end
    end
  end

  always_comb begin
    acc_d = ACC_W'(c_bias_q);
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      acc_d = acc_d + ACC_W'(row_sum_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= prod_valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready) begin
      row_sum_q <= row_sum_d;
      c_bias_q  <= bias_i;
      c_tag_q   <= tag_i;
    end
    if (d_ready) begin
      acc_q   <= acc_d;
      d_tag_q <= c_tag_q;
    end
  end

  // relu, then clamp to the top of the output range
  always_comb begin
    if (acc_q < 0) begin
      res_o.feature = '0;
    end else if (acc_q > $signed(ACC_W'(FEATURE_MAX))) begin
      res_o.feature = FEATURE_MAX;
    end else begin
      res_o.feature = acc_q[FEAT_W-1:0];
    end
    res_o.out_row  = d_tag_q.out_row;
    res_o.out_col  = d_tag_q.out_col;
    res_o.map_done = d_tag_q.map_done;
  end

  assign res_valid_o = d_valid_q;

endmodule

`default_nettype wire

// ----- hdl/cbr_skid.sv -----
`default_nettype none

module cbr_skid import cbr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  input  wire cbr_result_t s_data_i,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output cbr_result_t      m_data_o
);

  logic        m_valid_q, skid_valid_q;
  cbr_result_t m_data_q, skid_data_q;
  logic        s_fire, m_load;

  assign s_ready_o = !skid_valid_q;
  assign s_fire    = s_valid_i && !skid_valid_q;
  assign m_load    = !m_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q    <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (m_load) begin
      m_valid_q    <= skid_valid_q || s_fire;
      skid_valid_q <= 1'b0;
    end else if (s_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_data_q <= skid_valid_q ? skid_data_q : s_data_i;
    end else if (s_fire) begin
      skid_data_q <= s_data_i;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

endmodule

`default_nettype wire

// ----- hdl/conv5x5_bias_relu_stream.sv -----
// streaming 2-d valid convolution (kernel KERNEL_SIZE square) with bias and relu
// slave stream: one request per cycle unless stalled; tuser selects request kind
//   pixel: 8-bit sample, raster order over IMAGE_WIDTH x IMAGE_HEIGHT
//   weight load: coefficient goes to kernel tap weight_index (row*K+col),
//     an index past the last tap is dropped
//   bias load: coefficient becomes the bias; loads give no result
// master stream: one result per pixel whose row and column are both at least
//   K-1; feature is relu(window*kernel + bias) in q.12, clamped at 2^31-1,
//   tlast marks the result of the last pixel of the image
// throughput: one request per clock while not stalled, set by the parallel tap
//   multipliers and the line store with one read port and one write port
// path: a taken pixel passes the input reg, then products, row sums, total,
//   output reg
// reset: position returns to row 0 col 0, weights and bias clear to zero;
//   line store and window need no clearing, warm-up keeps them out of results
// stall: the output reg plus skid slot holds results while tready is low;
//   s_axis_tready stays high until every stage holds a request, then drops,
//   so up to six results can be held inside the block
`default_nettype none

module conv5x5_bias_relu_stream import cbr_pkg::*; #(
  parameter int KERNEL_SIZE  = KERNEL_SIZE_DEF,
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [4:0] weight_index, [22:5] coefficient, [30:23] pixel, [31] zero
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [30:0] feature, [35:31] out_row, [40:36] out_col, [47:41] zero
  output logic [47:0]      m_axis_tdata,
  // map_done
  output logic             m_axis_tlast
);

  localparam int TAPS = KERNEL_SIZE * KERNEL_SIZE;

  // field unpacking
  cbr_op_e                  in_op;
  logic [IDX_W-1:0]         in_idx;
  logic signed [COEF_W-1:0] in_coef;
  logic [PIX_W-1:0]         in_pixel;

  assign in_op    = cbr_op_e'(s_axis_tuser);
  assign in_idx   = s_axis_tdata[IDX_W-1:0];
  assign in_coef  = $signed(s_axis_tdata[IDX_W+COEF_W-1:IDX_W]);
  assign in_pixel = s_axis_tdata[IDX_W+COEF_W+PIX_W-1:IDX_W+COEF_W];

  // window/product stage to adder tree
  logic                     prod_valid, prod_ready;
  logic signed [PROD_W-1:0] prod [TAPS];
  logic signed [COEF_W-1:0] prod_bias;
  cbr_tag_t                 prod_tag;

  // adder tree to output buffer
  logic        res_valid, res_ready;
  cbr_result_t res;
  cbr_result_t out_res;

  cbr_window #(
    .KERNEL_SIZE  (KERNEL_SIZE),
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (in_op),
    .in_idx_i     (in_idx),
    .in_coef_i    (in_coef),
    .in_pixel_i   (in_pixel),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_o       (prod),
    .bias_o       (prod_bias),
    .tag_o        (prod_tag)
  );

  cbr_sum #(
    .KERNEL_SIZE (KERNEL_SIZE)
  ) u_sum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod),
    .bias_i       (prod_bias),
    .tag_i        (prod_tag),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register with one skid slot
  cbr_skid u_skid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (res_valid),
    .s_ready_o (res_ready),
    .s_data_i  (res),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (out_res)
  );

  assign m_axis_tdata = {7'b0, out_res.out_col, out_res.out_row, out_res.feature};
  assign m_axis_tlast = out_res.map_done;

endmodule

`default_nettype wire

// ----- tb/conv5x5_bias_relu_stream_tb.sv -----
`default_nettype none

module conv5x5_bias_relu_stream_tb;
  import cbr_pkg::*;

  localparam int KS    = KERNEL_SIZE_DEF;
  localparam int IMG_W = IMAGE_WIDTH_DEF;
  localparam int IMG_H = IMAGE_HEIGHT_DEF;
  localparam int TAPS  = KS * KS;

  // operation code the block has no use for
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 18'sh1FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 18'sh20000;
  localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sh01000;

  localparam int RANDOM_REQUESTS = 1535;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 12;
  localparam int CYCLE_LIMIT     = 200000;

  // one row of the directed part; a repeated weight load can step the index
  typedef struct {
    logic [1:0]               op;
    logic [IDX_W-1:0]         idx;
    logic signed [COEF_W-1:0] coef;
    logic [PIX_W-1:0]         pix;
    int                       reps;
    bit                       idx_step;
    bit                       typed;
    cbr_result_t              want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  // predictor state
  logic [PIX_W-1:0]         line_rows [KS-1][IMG_W];
  logic [PIX_W-1:0]         win_px [KS][KS];
  logic signed [COEF_W-1:0] kernel_taps [TAPS];
  logic signed [COEF_W-1:0] kernel_bias_q;
  int                       pos_row;
  int                       pos_col;

  cbr_result_t pending_features [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          long_hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  conv5x5_bias_relu_stream i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // directed rows: warm-up fill, zero kernel after reset, bias extremes,
  // dropped weight loads, unused operation, all-max and all-min kernels
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_PIXEL,  5'd0,  18'sd0,   8'd255, 132, 1'b0, 1'b0, '0},
    '{OP_PIXEL,  5'd0,  18'sd0,   8'd0,   1,   1'b0, 1'b1, {31'd0, 5'd0, 5'd0, 1'b0}},
    '{OP_BIAS,   5'd0,  COEF_MAX, 8'd0,   1,   1'b0, 1'b0, '0},
    '{OP_PIXEL,  5'd0,  18'sd0,   8'd128, 1,   1'b0, 1'b1, {31'd131071, 5'd0, 5'd1, 1'b0}},
    '{OP_BIAS,   5'd0,  COEF_MIN, 8'd0,   1,   1'b0, 1'b0, '0},
    '{OP_PIXEL,  5'd0,  18'sd0,   8'd7,   1,   1'b0, 1'b1, {31'd0, 5'd0, 5'd2, 1'b0}},
    '{OP_WEIGHT, 5'd31, COEF_MAX, 8'd0,   1,   1'b0, 1'b0, '0},
    '{OP_WEIGHT, 5'd25, COEF_MIN, 8'd0,   1,   1'b0, 1'b0, '0},
    '{OP_UNUSED, 5'd31, -18'sd1,  8'd255, 1,   1'b0, 1'b0, '0},
    '{OP_PIXEL,  5'd0,  18'sd0,   8'd3,   1,   1'b0, 1'b1, {31'd0, 5'd0, 5'd3, 1'b0}},
    '{OP_WEIGHT, 5'd0,  COEF_MAX, 8'd0,   TAPS, 1'b1, 1'b0, '0},
    '{OP_BIAS,   5'd0,  COEF_MAX, 8'd0,   1,   1'b0, 1'b0, '0},
    '{OP_PIXEL,  5'd0,  18'sd0,   8'd255, 160, 1'b0, 1'b0, '0},
    '{OP_WEIGHT, 5'd0,  COEF_MIN, 8'd0,   TAPS, 1'b1, 1'b0, '0},
    '{OP_BIAS,   5'd0,  18'sd0,   8'd0,   1,   1'b0, 1'b0, '0},
    '{OP_PIXEL,  5'd0,  18'sd0,   8'd255, 4,   1'b0, 1'b0, '0},
    '{OP_WEIGHT, 5'd12, COEF_ONE, 8'd0,   1,   1'b0, 1'b0, '0},
    '{OP_WEIGHT, 5'd24, COEF_MAX, 8'd0,   1,   1'b0, 1'b0, '0},
    '{OP_PIXEL,  5'd0,  18'sd0,   8'd0,   3,   1'b0, 1'b0, '0},
    '{OP_PIXEL,  5'd0,  18'sd0,   8'd255, 3,   1'b0, 1'b0, '0}
  };

  // apply one request to the predictor, give the feature it causes if any
  function automatic void conv_window_predict(input logic [1:0] op,
                                               input logic [IDX_W-1:0] idx,
                                               input logic signed [COEF_W-1:0] coef,
                                               input logic [PIX_W-1:0] pix,
                                               output bit has_feature,
                                               output cbr_result_t feat);
    logic [PIX_W-1:0] column [KS];
    longint acc;
    has_feature = 1'b0;
    feat = '0;
    case (op)
      OP_WEIGHT: begin
        if (idx < TAPS) kernel_taps[idx] = coef;
      end
      OP_BIAS: begin
        kernel_bias_q = coef;
      end
      OP_PIXEL: begin
        // new column: older rows from the line stores, newest pixel at the bottom
        for (int i = 0; i < KS - 1; i++) column[i] = line_rows[i][pos_col];
        column[KS-1] = pix;
        for (int i = 0; i < KS - 1; i++)
          line_rows[i][pos_col] = (i + 1 < KS - 1) ? line_rows[i+1][pos_col] : pix;
        for (int i = 0; i < KS; i++) begin
          for (int j = 0; j < KS - 1; j++) win_px[i][j] = win_px[i][j+1];
          win_px[i][KS-1] = column[i];
        end
        if (pos_row >= KS - 1 && pos_col >= KS - 1) begin
          acc = longint'(kernel_bias_q);
          for (int i = 0; i < KS; i++)
            for (int j = 0; j < KS; j++)
              acc += longint'(win_px[i][j]) * longint'(kernel_taps[i*KS+j]);
          if (acc < 0) acc = 0;
          if (acc > longint'(FEATURE_MAX)) acc = longint'(FEATURE_MAX);
          feat.feature  = acc[FEAT_W-1:0];
          feat.out_row  = POS_OUT_W'(pos_row - (KS - 1));
          feat.out_col  = POS_OUT_W'(pos_col - (KS - 1));
          feat.map_done = (pos_row == IMG_H - 1) && (pos_col == IMG_W - 1);
          has_feature = 1'b1;
        end
        pos_col++;
        if (pos_col >= IMG_W) begin
          pos_col = 0;
          pos_row++;
          if (pos_row >= IMG_H) pos_row = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // offer one request in bursts with random gaps, hold it until taken,
  // then record what it should produce; a typed row overrides the predictor
  task automatic offer_request(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                               input logic signed [COEF_W-1:0] coef,
                               input logic [PIX_W-1:0] pix,
                               input bit typed, input cbr_result_t typed_want);
    int gap;
    bit has_feature;
    cbr_result_t feat;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, pix, coef, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    conv_window_predict(op, idx, coef, pix, has_feature, feat);
    if (has_feature) pending_features.push_back(typed ? typed_want : feat);
  endtask

  // stop offering and let every expected feature come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_features.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coefficient();
    logic signed [COEF_W-1:0] c;
    case ($urandom_range(0, 3))
      0: c = COEF_W'($urandom);
      1: c = COEF_W'($urandom_range(0, 4095)) - 18'sd2048;
      2: c = COEF_W'($urandom_range(0, 32767));
      default: begin
        case ($urandom_range(0, 3))
          0: c = COEF_MAX;
          1: c = COEF_MIN;
          2: c = 18'sd0;
          default: c = -18'sd1;
        endcase
      end
    endcase
    return c;
  endfunction

  // receiver: stall rate is picked anew for each phase, including phases
  // with no stall, plus one long hold-off on request
  always @(posedge clk_i) begin : receiver_stall
    static int hold_cnt = 0;
    static int stall_pct = 0;
    static int phase_cnt = 0;
    if (phase_cnt == 0) begin
      phase_cnt = 100;
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    phase_cnt--;
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // compare each taken feature with the oldest expectation
  always @(posedge clk_i) begin : feature_check
    cbr_result_t got;
    cbr_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[30:0], m_axis_tdata[35:31], m_axis_tdata[40:36], m_axis_tlast};
      if (pending_features.size() == 0) begin
        $display("%0t: unexpected feature %0d row %0d col %0d done %0d", $time,
                 got.feature, got.out_row, got.out_col, got.map_done);
        mismatch_count++;
      end else begin
        want = pending_features.pop_front();
        if (got !== want) begin
          $display("%0t: expected feature %0d row %0d col %0d done %0d", $time,
                   want.feature, want.out_row, want.out_col, want.map_done);
          $display("%0t:   actual feature %0d row %0d col %0d done %0d", $time,
                   got.feature, got.out_row, got.out_col, got.map_done);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : run_limit
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [1:0] op;
    logic [IDX_W-1:0] idx;
    logic signed [COEF_W-1:0] coef;
    logic [PIX_W-1:0] pix;
    int pick;

    foreach (line_rows[i, j]) line_rows[i][j] = '0;
    foreach (win_px[i, j]) win_px[i][j] = '0;
    foreach (kernel_taps[i]) kernel_taps[i] = '0;
    kernel_bias_q = '0;
    pos_row = 0;
    pos_col = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        offer_request(directed_rows[r].op,
                      directed_rows[r].idx + (directed_rows[r].idx_step ? IDX_W'(k) : '0),
                      directed_rows[r].coef, directed_rows[r].pix,
                      directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // random part: mostly pixels so frames run through, loads mixed in
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // long receiver hold-off while requests keep coming
      if (n == 300) long_hold_req = 1'b1;
      // sender pause until the pipeline is empty
      if (n == 950) wait_drained();
      pick = $urandom_range(0, 99);
      idx  = IDX_W'($urandom_range(0, TAPS - 1));
      coef = pick_coefficient();
      pix  = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                          : PIX_W'($urandom);
      if (pick < 84) begin
        op = OP_PIXEL;
      end else if (pick < 92) begin
        op = OP_WEIGHT;
      end else if (pick < 96) begin
        op = OP_BIAS;
      end else if (pick < 98) begin
        // index past the last tap, dropped
        op = OP_WEIGHT;
        idx = IDX_W'($urandom_range(TAPS, 31));
      end else begin
        op = OP_UNUSED;
      end
      offer_request(op, idx, coef, pix, 1'b0, '0);
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
